FILE: design/lap_pkg.sv
package lap_pkg;

	// Q1.15 unity, also the ceiling for depth and gain registers.
	localparam logic [15:0] Q15_ONE = 16'h8000;

	// Unity of the Q16 fraction within one quarter turn.
	localparam logic [16:0] FRAC_ONE = 17'h10000;

	// Sine polynomial coefficients, Q16.
	localparam logic [18:0] POLY_C3 = 19'd4640;
	localparam logic [16:0] POLY_C2 = 17'd42048;
	localparam logic [16:0] POLY_C1 = 17'd102944;

	// Number of words the front can run ahead of the back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Register reset values.
	localparam logic [15:0] PAN_DEPTH_RST = 16'd32768;
	localparam logic [31:0] PAN_STEP_RST = 32'd2684355;
	localparam logic [15:0] MOD_DEPTH_RST = 16'd0;
	localparam logic [31:0] MOD_STEP_RST = 32'd0;
	localparam logic [15:0] OUT_GAIN_RST = 16'd16384;

	// Register indexes on the write port.
	typedef enum logic [2:0] {
		REG_PAN_DEPTH,
		REG_PAN_STEP,
		REG_MOD_DEPTH,
		REG_MOD_STEP,
		REG_OUT_GAIN
	} cfg_reg_t;

	// Phase folded into a quadrant and a Q16 fraction within that quadrant.
	typedef struct packed {
		logic [1:0]  quad;
		logic [16:0] frac;
	} sine_arg_t;

	// Classified word handed from the front to the back (sample travels beside it).
	typedef struct packed {
		logic      last;
		sine_arg_t arg_pan;
		sine_arg_t arg_mod;
	} lfo_item_t;

	// Clamped depth and gain values used by the back.
	typedef struct packed {
		logic [15:0] pan_depth;
		logic [15:0] mod_depth;
		logic [15:0] gain;
	} lfo_gains_t;

	// Back sequencer states: idle, one per multiplier step, and done.
	typedef enum logic [3:0] {
		BK_IDLE,
		BK_X2,
		BK_T,
		BK_U,
		BK_Y,
		BK_DEP,
		BK_AMP,
		BK_AX,
		BK_G,
		BK_DONE
	} back_state_t;

	// Values above one act as one.
	function automatic logic [15:0] clamp_q15(input logic [15:0] v);
		return (v > Q15_ONE) ? Q15_ONE : v;
	endfunction

	// Split a quantized angle into quadrant and mirrored quarter fraction.
	function automatic sine_arg_t fold_angle(input logic [31:0] angle);
		sine_arg_t arg;
		arg.quad = angle[31:30];
		arg.frac = angle[30] ? (FRAC_ONE - {1'b0, angle[29:14]}) : {1'b0, angle[29:14]};
		return arg;
	endfunction

endpackage

FILE: design/lap_front.sv
module lap_front #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned SINE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          last_of_file,
	input  logic [31:0]                   pan_step,
	input  logic [31:0]                   mod_step,
	input  logic                          full,
	output logic                          push,
	output logic [SAMPLE_BITS-1:0]        push_sample,
	output lap_pkg::lfo_item_t            push_item
);

	// Phase bits below the table resolution are dropped.
	localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - SINE_BITS)) - 32'd1);

	logic [31:0] pan_phase_q;
	logic [31:0] mod_phase_q;

	// A word is taken whenever the queue has room.
	assign in_stall = full;
	assign push     = in_valid && !full;

	// Classify the word: sample, end flag and both folded LFO angles.
	assign push_sample       = sample_in;
	assign push_item.last    = last_of_file;
	assign push_item.arg_pan = lap_pkg::fold_angle(pan_phase_q & ANGLE_MASK);
	assign push_item.arg_mod = lap_pkg::fold_angle(mod_phase_q & ANGLE_MASK);

	// Phase accumulators advance per word and restart after the end of a stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_phase_q <= '0;
			mod_phase_q <= '0;
		end else if (push) begin
			if (last_of_file) begin
				pan_phase_q <= '0;
				mod_phase_q <= '0;
			end else begin
				pan_phase_q <= pan_phase_q + pan_step;
				mod_phase_q <= mod_phase_q + mod_step;
			end
		end
	end

endmodule

FILE: design/lap_queue.sv
module lap_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_BITS = (lap_pkg::QUEUE_DEPTH > 1) ?
		$clog2(lap_pkg::QUEUE_DEPTH) : 1;
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(lap_pkg::QUEUE_DEPTH - 1);
	localparam logic [PTR_BITS:0] COUNT_FULL = (PTR_BITS + 1)'(lap_pkg::QUEUE_DEPTH);

	logic [WIDTH-1:0]    slot_q [lap_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   count_q;

	assign full     = (count_q == COUNT_FULL);
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// The fill count never passes the number of slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_FULL)
		else $error("queue count above depth");

	// The back only takes a word that is there.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");
`endif

endmodule

FILE: design/lap_back.sv
module lap_back #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lap_pkg::lfo_gains_t           gains,
	input  logic                          empty,
	output logic                          pop,
	input  logic [SAMPLE_BITS-1:0]        pop_sample,
	input  lap_pkg::lfo_item_t            pop_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          end_mark
);

	localparam int unsigned OPB_W = 19;
	localparam int unsigned OPA_W = SAMPLE_BITS + 19;
	localparam int unsigned PR_W  = OPA_W + OPB_W;
	localparam int unsigned RND_W = PR_W - 30;
	localparam logic signed [PR_W-1:0] HALF15 = PR_W'(16384);
	localparam logic signed [PR_W-1:0] HALF30 = PR_W'(32'd536870912);
	localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [RND_W-1:0] SAT_MIN = ~SAT_MAX;
	localparam logic signed [18:0] FAC_ONE = 19'sd32768;
	localparam logic [17:0] AMP_MAX = 18'd131068;

	lap_pkg::back_state_t state_q, state_d;

	logic                          out_free;
	logic                          load_out;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;
	logic                          end_q;

	// Per-lane working registers: pan/mod lanes first, then left/right lanes.
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          last_q;
	logic [1:0]                    quad_q [2];
	logic [16:0]                   frac_q [2];
	logic [16:0]                   x2_q   [2];
	logic [16:0]                   t_q    [2];
	logic [16:0]                   u_q    [2];
	logic [16:0]                   y_q    [2];
	logic signed [17:0]            p_q    [2];
	logic [17:0]                   amp_q  [2];
	logic signed [OPA_W-1:0]       ax_q   [2];
	logic signed [PR_W-1:0]        gp_q   [2];

	logic [32:0]              mag_sum  [2];
	logic [15:0]              mag      [2];
	logic signed [17:0]       sine     [2];
	logic [15:0]              depth    [2];
	logic signed [18:0]       fac_a    [2];
	logic signed [18:0]       fac_b    [2];
	logic signed [OPA_W-1:0]  op_a     [2];
	logic signed [OPB_W-1:0]  op_b     [2];
	logic signed [PR_W-1:0]   prod     [2];
	logic signed [PR_W-1:0]   half_rnd [2];
	logic signed [PR_W-1:0]   out_rnd  [2];
	logic signed [RND_W-1:0]  shifted  [2];
	logic signed [SAMPLE_BITS-1:0] sat [2];

	assign out_free = !out_valid_q || !out_stall;
	assign depth[0] = gains.pan_depth;
	assign depth[1] = gains.mod_depth;

	// Sine magnitude from the polynomial result, signed by quadrant.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mag_sum[i] = {1'b0, y_q[i], 15'd0} - 33'(y_q[i]) + 33'd32768;
			mag[i]     = mag_sum[i][31:16];
			sine[i]    = quad_q[i][1] ? -$signed({2'b00, mag[i]}) : $signed({2'b00, mag[i]});
		end
	end

	// Panning factors: left uses one plus, right uses one minus.
	assign fac_a[0] = FAC_ONE + 19'(p_q[0]);
	assign fac_b[0] = FAC_ONE + 19'(p_q[1]);
	assign fac_a[1] = FAC_ONE - 19'(p_q[0]);
	assign fac_b[1] = FAC_ONE - 19'(p_q[1]);

	// Operand selection for the two shared multipliers.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			op_a[i] = '0;
			op_b[i] = '0;
			case (state_q)
				lap_pkg::BK_X2: begin
					op_a[i] = OPA_W'(frac_q[i]);
					op_b[i] = OPB_W'(frac_q[i]);
				end
				lap_pkg::BK_T: begin
					op_a[i] = OPA_W'(x2_q[i]);
					op_b[i] = lap_pkg::POLY_C3;
				end
				lap_pkg::BK_U: begin
					op_a[i] = OPA_W'(x2_q[i]);
					op_b[i] = OPB_W'(t_q[i]);
				end
				lap_pkg::BK_Y: begin
					op_a[i] = OPA_W'(frac_q[i]);
					op_b[i] = OPB_W'(u_q[i]);
				end
				lap_pkg::BK_DEP: begin
					op_a[i] = OPA_W'(sine[i]);
					op_b[i] = OPB_W'(depth[i]);
				end
				lap_pkg::BK_AMP: begin
					op_a[i] = OPA_W'(fac_a[i]);
					op_b[i] = fac_b[i];
				end
				lap_pkg::BK_AX: begin
					op_a[i] = OPA_W'(sample_q);
					op_b[i] = OPB_W'(amp_q[i]);
				end
				lap_pkg::BK_G: begin
					op_a[i] = ax_q[i];
					op_b[i] = OPB_W'(gains.gain);
				end
				default: begin
					op_a[i] = '0;
					op_b[i] = '0;
				end
			endcase
		end
	end

	// Multipliers and rounding of their products.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			prod[i]     = op_a[i] * op_b[i];
			half_rnd[i] = prod[i] + HALF15;
			out_rnd[i]  = gp_q[i] + HALF30;
			shifted[i]  = out_rnd[i][PR_W-1:30];
			if (shifted[i] > SAT_MAX) begin
				sat[i] = SAT_MAX[SAMPLE_BITS-1:0];
			end else if (shifted[i] < SAT_MIN) begin
				sat[i] = SAT_MIN[SAMPLE_BITS-1:0];
			end else begin
				sat[i] = shifted[i][SAMPLE_BITS-1:0];
			end
		end
	end

	// Step results are kept per lane.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			case (state_q)
				lap_pkg::BK_IDLE: begin
					if (!empty) begin
						quad_q[i] <= (i == 0) ? pop_item.arg_pan.quad : pop_item.arg_mod.quad;
						frac_q[i] <= (i == 0) ? pop_item.arg_pan.frac : pop_item.arg_mod.frac;
					end
				end
				lap_pkg::BK_X2:  x2_q[i]  <= prod[i][32:16];
				lap_pkg::BK_T:   t_q[i]   <= lap_pkg::POLY_C2 - prod[i][32:16];
				lap_pkg::BK_U:   u_q[i]   <= lap_pkg::POLY_C1 - prod[i][32:16];
				lap_pkg::BK_Y:   y_q[i]   <= prod[i][32:16];
				lap_pkg::BK_DEP: p_q[i]   <= half_rnd[i][32:15];
				lap_pkg::BK_AMP: amp_q[i] <= half_rnd[i][32:15];
				lap_pkg::BK_AX:  ax_q[i]  <= prod[i][OPA_W-1:0];
				lap_pkg::BK_G:   gp_q[i]  <= prod[i];
				default: ;
			endcase
		end
		if (state_q == lap_pkg::BK_IDLE && !empty) begin
			sample_q <= pop_sample;
			last_q   <= pop_item.last;
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lap_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, queue pop and output load.
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			lap_pkg::BK_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = lap_pkg::BK_X2;
				end
			end
			lap_pkg::BK_X2:  state_d = lap_pkg::BK_T;
			lap_pkg::BK_T:   state_d = lap_pkg::BK_U;
			lap_pkg::BK_U:   state_d = lap_pkg::BK_Y;
			lap_pkg::BK_Y:   state_d = lap_pkg::BK_DEP;
			lap_pkg::BK_DEP: state_d = lap_pkg::BK_AMP;
			lap_pkg::BK_AMP: state_d = lap_pkg::BK_AX;
			lap_pkg::BK_AX:  state_d = lap_pkg::BK_G;
			lap_pkg::BK_G:   state_d = lap_pkg::BK_DONE;
			lap_pkg::BK_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = lap_pkg::BK_IDLE;
				end
			end
			default: state_d = lap_pkg::BK_IDLE;
		endcase
	end

	// Output register: holds a finished word while the next one is computed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			left_q  <= sat[0];
			right_q <= sat[1];
			end_q   <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign end_mark  = end_q;

`ifndef SYNTHESIS
	// The first multiplier step always follows a queue pop.
	a_step_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lap_pkg::BK_X2 |-> $past(state_q) == lap_pkg::BK_IDLE)
		else $error("sequencer started without loading a word");

	// A new result appears only from the store step.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == lap_pkg::BK_DONE)
		else $error("output valid raised outside the store step");

	// Amplitude products stay within the range of two Q1.15 factors.
	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lap_pkg::BK_AX |-> amp_q[0] <= AMP_MAX && amp_q[1] <= AMP_MAX)
		else $error("amplitude out of range");
`endif

endmodule

FILE: design/lfo_auto_panner.sv
// An accepted word is written to the queue, popped by the back in its idle state,
// run through the back sequencer's eight steps on its two shared multipliers and
// stored in the output register from the done state before the back takes another.
// A two-word queue lets the front accept while the back works and a result waits.
// Reset (arst_n low, asynchronous): phases cleared, registers to defaults,
// queue empty, no output valid.
module lfo_auto_panner #(
	parameter int unsigned SINE_ENTRIES = 1024,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [2:0]                    cfg_addr,
	input  logic [31:0]                   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          last_of_file,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          end_mark
);

	localparam int unsigned SINE_BITS = $clog2(SINE_ENTRIES);
	localparam int unsigned ITEM_W = $bits(lap_pkg::lfo_item_t) + SAMPLE_BITS;

	logic [15:0] pan_depth_q;
	logic [31:0] pan_step_q;
	logic [15:0] mod_depth_q;
	logic [31:0] mod_step_q;
	logic [15:0] out_gain_q;

	lap_pkg::lfo_gains_t gains;
	lap_pkg::lfo_item_t  push_item;
	logic [SAMPLE_BITS-1:0] push_sample;
	logic [ITEM_W-1:0]   pop_data;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_depth_q <= lap_pkg::PAN_DEPTH_RST;
			pan_step_q  <= lap_pkg::PAN_STEP_RST;
			mod_depth_q <= lap_pkg::MOD_DEPTH_RST;
			mod_step_q  <= lap_pkg::MOD_STEP_RST;
			out_gain_q  <= lap_pkg::OUT_GAIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				lap_pkg::REG_PAN_DEPTH: pan_depth_q <= cfg_wdata[15:0];
				lap_pkg::REG_PAN_STEP:  pan_step_q  <= cfg_wdata;
				lap_pkg::REG_MOD_DEPTH: mod_depth_q <= cfg_wdata[15:0];
				lap_pkg::REG_MOD_STEP:  mod_step_q  <= cfg_wdata;
				lap_pkg::REG_OUT_GAIN:  out_gain_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Depth and gain above one act as one.
	assign gains.pan_depth = lap_pkg::clamp_q15(pan_depth_q);
	assign gains.mod_depth = lap_pkg::clamp_q15(mod_depth_q);
	assign gains.gain      = lap_pkg::clamp_q15(out_gain_q);

	// Front: accepts words, runs the phase accumulators, folds the angles.
	lap_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.SINE_BITS   (SINE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.last_of_file (last_of_file),
		.pan_step     (pan_step_q),
		.mod_step     (mod_step_q),
		.full         (full),
		.push         (push),
		.push_sample  (push_sample),
		.push_item    (push_item)
	);

	// Queue between front and back.
	lap_queue #(
		.WIDTH (ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_item, push_sample}),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	// Back: sine polynomial, panning factors, gain and output register.
	lap_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gains      (gains),
		.empty      (empty),
		.pop        (pop),
		.pop_sample (pop_data[SAMPLE_BITS-1:0]),
		.pop_item   (lap_pkg::lfo_item_t'(pop_data[ITEM_W-1:SAMPLE_BITS])),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.left_out   (left_out),
		.right_out  (right_out),
		.end_mark   (end_mark)
	);

endmodule
